FILE: hdl/aavr_pkg.sv
// Shared types, widths and constants for the axis-angle vector rotation pipeline.
`default_nettype none
package aavr_pkg;

	// Fixed-point layout
	localparam int FRAC_W = 14;
	localparam int VEC_W  = 32;
	localparam int ANG_W  = 16;

	// Intermediate widths, sized from the operand ranges
	localparam int AA_W   = 2 * ANG_W;            // a_i * a_j, a_k * s
	localparam int P_W    = AA_W - FRAC_W;        // axis product after shift
	localparam int OMC_W  = ANG_W + 1;            // one minus cosine
	localparam int PO_W   = P_W + OMC_W;          // p_ij * omc
	localparam int T_W    = PO_W - FRAC_W;        // scaled outer-product term
	localparam int M_W    = T_W + 1;              // matrix entry
	localparam int PR_W   = M_W + VEC_W;          // matrix entry times vector component
	localparam int ACC_W  = PR_W + 2;             // sum of three products
	localparam int SH_W   = ACC_W - FRAC_W;       // row sum after shift

	// One in Q1.14, widened to the one-minus-cosine width
	localparam logic signed [OMC_W-1:0] ONE_Q14 = OMC_W'(16384);

	// Input beat
	typedef struct packed {
		logic signed [VEC_W-1:0] vec_x;
		logic signed [VEC_W-1:0] vec_y;
		logic signed [VEC_W-1:0] vec_z;
		logic signed [ANG_W-1:0] axis_x;
		logic signed [ANG_W-1:0] axis_y;
		logic signed [ANG_W-1:0] axis_z;
		logic signed [ANG_W-1:0] cos_angle;
		logic signed [ANG_W-1:0] sin_angle;
	} item_t;

	// Output beat
	typedef struct packed {
		logic signed [VEC_W-1:0] rot_x;
		logic signed [VEC_W-1:0] rot_y;
		logic signed [VEC_W-1:0] rot_z;
	} result_t;

endpackage
`default_nettype wire

FILE: hdl/aavr_row_sum.sv
// Sum of one matrix row's three products, Q.14 rescale and 32-bit saturation.
`default_nettype none
module aavr_row_sum (
	input  wire logic signed [aavr_pkg::PR_W-1:0]  prod0,
	input  wire logic signed [aavr_pkg::PR_W-1:0]  prod1,
	input  wire logic signed [aavr_pkg::PR_W-1:0]  prod2,
	output logic signed [aavr_pkg::VEC_W-1:0]      rot
);

	logic signed [aavr_pkg::ACC_W-1:0] acc;
	logic signed [aavr_pkg::SH_W-1:0]  shifted;
	logic                               fits;

	// Sum at full precision, then drop the fraction bits (floor)
	always_comb begin
		acc     = aavr_pkg::ACC_W'(prod0) + aavr_pkg::ACC_W'(prod1)
			+ aavr_pkg::ACC_W'(prod2);
		shifted = acc[aavr_pkg::ACC_W-1:aavr_pkg::FRAC_W];
	end

	// Clamp to the signed 32-bit range
	always_comb begin
		fits = (shifted[aavr_pkg::SH_W-1:aavr_pkg::VEC_W-1]
			== {(aavr_pkg::SH_W-aavr_pkg::VEC_W+1){shifted[aavr_pkg::SH_W-1]}});
		if (fits) begin
			rot = shifted[aavr_pkg::VEC_W-1:0];
		end else if (shifted[aavr_pkg::SH_W-1]) begin
			rot = {1'b1, {(aavr_pkg::VEC_W-1){1'b0}}};
		end else begin
			rot = {1'b0, {(aavr_pkg::VEC_W-1){1'b1}}};
		end
	end

endmodule
`default_nettype wire

FILE: hdl/axis_angle_vector_rotation.sv
// Top level: four-stage Rodrigues rotation pipeline with valid/ready on both sides.
// Throughput: one beat per cycle; each stage holds while the stage after it is full
// and stalled, and an empty stage takes a new beat even while the output waits.
// Stages: axis products, outer-product scaling, matrix-by-vector products, row sums.
// Reset: arst_n clears all stage valid bits at once; data registers are not reset.
`default_nettype none
module axis_angle_vector_rotation (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire aavr_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output aavr_pkg::result_t      result
);

	localparam int P_W   = aavr_pkg::P_W;
	localparam int T_W   = aavr_pkg::T_W;
	localparam int M_W   = aavr_pkg::M_W;
	localparam int PR_W  = aavr_pkg::PR_W;
	localparam int VEC_W = aavr_pkg::VEC_W;
	localparam int ANG_W = aavr_pkg::ANG_W;
	localparam int AA_W  = aavr_pkg::AA_W;
	localparam int PO_W  = aavr_pkg::PO_W;
	localparam int OMC_W = aavr_pkg::OMC_W;
	localparam int FR    = aavr_pkg::FRAC_W;

	// Stage valid bits and per-stage ready
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	always_comb begin
		rdy4       = !v_s4 || result_ready;
		rdy3       = !v_s3 || rdy4;
		rdy2       = !v_s2 || rdy3;
		rdy1       = !v_s1 || rdy2;
		item_ready = rdy1;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= item_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// ---------------- Stage 1: axis products, sine terms, one minus cosine
	logic signed [ANG_W-1:0] ax, ay, az, cs, sn;
	logic signed [AA_W-1:0]  m_xx, m_yy, m_zz, m_xy, m_xz, m_yz, m_qx, m_qy, m_qz;
	logic signed [OMC_W-1:0] omc;

	always_comb begin
		ax   = item.axis_x;
		ay   = item.axis_y;
		az   = item.axis_z;
		cs   = item.cos_angle;
		sn   = item.sin_angle;
		m_xx = ax * ax;
		m_yy = ay * ay;
		m_zz = az * az;
		m_xy = ax * ay;
		m_xz = ax * az;
		m_yz = ay * az;
		m_qx = ax * sn;
		m_qy = ay * sn;
		m_qz = az * sn;
		omc  = aavr_pkg::ONE_Q14 - OMC_W'(cs);
	end

	logic signed [P_W-1:0]   pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;
	logic signed [P_W-1:0]   qx_s1, qy_s1, qz_s1;
	logic signed [OMC_W-1:0] omc_s1;
	logic signed [ANG_W-1:0] cos_s1;
	logic signed [VEC_W-1:0] vx_s1, vy_s1, vz_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && item_valid) begin
			pxx_s1 <= m_xx[AA_W-1:FR];
			pyy_s1 <= m_yy[AA_W-1:FR];
			pzz_s1 <= m_zz[AA_W-1:FR];
			pxy_s1 <= m_xy[AA_W-1:FR];
			pxz_s1 <= m_xz[AA_W-1:FR];
			pyz_s1 <= m_yz[AA_W-1:FR];
			qx_s1  <= m_qx[AA_W-1:FR];
			qy_s1  <= m_qy[AA_W-1:FR];
			qz_s1  <= m_qz[AA_W-1:FR];
			omc_s1 <= omc;
			cos_s1 <= cs;
			vx_s1  <= item.vec_x;
			vy_s1  <= item.vec_y;
			vz_s1  <= item.vec_z;
		end
	end

	// ---------------- Stage 2: scale outer products by one minus cosine
	logic signed [PO_W-1:0] o_xx, o_yy, o_zz, o_xy, o_xz, o_yz;

	always_comb begin
		o_xx = pxx_s1 * omc_s1;
		o_yy = pyy_s1 * omc_s1;
		o_zz = pzz_s1 * omc_s1;
		o_xy = pxy_s1 * omc_s1;
		o_xz = pxz_s1 * omc_s1;
		o_yz = pyz_s1 * omc_s1;
	end

	logic signed [T_W-1:0]   txx_s2, tyy_s2, tzz_s2, txy_s2, txz_s2, tyz_s2;
	logic signed [P_W-1:0]   qx_s2, qy_s2, qz_s2;
	logic signed [ANG_W-1:0] cos_s2;
	logic signed [VEC_W-1:0] vx_s2, vy_s2, vz_s2;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			txx_s2 <= o_xx[PO_W-1:FR];
			tyy_s2 <= o_yy[PO_W-1:FR];
			tzz_s2 <= o_zz[PO_W-1:FR];
			txy_s2 <= o_xy[PO_W-1:FR];
			txz_s2 <= o_xz[PO_W-1:FR];
			tyz_s2 <= o_yz[PO_W-1:FR];
			qx_s2  <= qx_s1;
			qy_s2  <= qy_s1;
			qz_s2  <= qz_s1;
			cos_s2 <= cos_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			vz_s2  <= vz_s1;
		end
	end

	// ---------------- Stage 3: assemble matrix, multiply by vector
	logic signed [M_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;

	always_comb begin
		e00 = M_W'(txx_s2) + M_W'(cos_s2);
		e11 = M_W'(tyy_s2) + M_W'(cos_s2);
		e22 = M_W'(tzz_s2) + M_W'(cos_s2);
		e01 = M_W'(txy_s2) - M_W'(qz_s2);
		e10 = M_W'(txy_s2) + M_W'(qz_s2);
		e02 = M_W'(txz_s2) + M_W'(qy_s2);
		e20 = M_W'(txz_s2) - M_W'(qy_s2);
		e12 = M_W'(tyz_s2) - M_W'(qx_s2);
		e21 = M_W'(tyz_s2) + M_W'(qx_s2);
	end

	logic signed [PR_W-1:0] p00_s3, p01_s3, p02_s3, p10_s3, p11_s3, p12_s3;
	logic signed [PR_W-1:0] p20_s3, p21_s3, p22_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			p00_s3 <= e00 * vx_s2;
			p01_s3 <= e01 * vy_s2;
			p02_s3 <= e02 * vz_s2;
			p10_s3 <= e10 * vx_s2;
			p11_s3 <= e11 * vy_s2;
			p12_s3 <= e12 * vz_s2;
			p20_s3 <= e20 * vx_s2;
			p21_s3 <= e21 * vy_s2;
			p22_s3 <= e22 * vz_s2;
		end
	end

	// ---------------- Stage 4: row sums, rescale, saturate into the output register
	logic signed [VEC_W-1:0] row_x, row_y, row_z;

	aavr_row_sum u_row_x (.prod0(p00_s3), .prod1(p01_s3), .prod2(p02_s3), .rot(row_x));
	aavr_row_sum u_row_y (.prod0(p10_s3), .prod1(p11_s3), .prod2(p12_s3), .rot(row_y));
	aavr_row_sum u_row_z (.prod0(p20_s3), .prod1(p21_s3), .prod2(p22_s3), .rot(row_z));

	aavr_pkg::result_t res_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			res_s4.rot_x <= row_x;
			res_s4.rot_y <= row_y;
			res_s4.rot_z <= row_z;
		end
	end

	always_comb begin
		result_valid = v_s4;
		result       = res_s4;
	end

`ifndef ASSERT_OFF
	// An empty first stage always takes a beat
	a_bubble_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> item_ready)
		else $error("empty first stage refused an input beat");

	// A full, stalled pipeline accepts nothing
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && v_s4 && !result_ready) |-> !item_ready)
		else $error("full stalled pipeline accepted an input beat");

	// An accepted beat lands in stage one
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> v_s1)
		else $error("accepted beat lost before stage one");

	// A stalled stage-three beat holds its products
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy4) |=> (v_s3 && $stable(p00_s3) && $stable(p11_s3)
			&& $stable(p22_s3)))
		else $error("stage three changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: sim/axis_angle_vector_rotation_tb.sv
// Self-checking testbench for the axis-angle vector rotation pipeline.
`timescale 1ns / 1ps
module axis_angle_vector_rotation_tb;

	localparam int CLK_HIGH        = 5;
	localparam int CLK_LOW         = 5;
	localparam int RESET_CYCLES    = 10;
	localparam int RANDOM_ITEMS    = 700;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int DRAIN_CYCLES    = 16;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int Q14_ONE         = 16384;
	localparam int VEC_MAX         = 32'h7fff_ffff;
	localparam int VEC_MIN         = 32'h8000_0000;
	localparam int ANG_MAX         = 32767;
	localparam int ANG_MIN         = -32768;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_ONE_IN_THREE, RX_MOSTLY} rx_mode_t;

	// Rotation predictor plus the queue of rotated vectors still owed by the block
	class rotation_scoreboard;
		aavr_pkg::result_t expected_rot[$];
		int unsigned       errors;

		function new();
			errors = 0;
		endfunction

		// Rodrigues matrix in Q.14, then matrix times vector with one shift per row
		function aavr_pkg::result_t predict_rotation(aavr_pkg::item_t it);
			longint            v[3];
			longint            a[3];
			longint            q[3];
			longint            m[3][3];
			longint            c, s, omc, p, t, acc;
			int                rot[3];
			aavr_pkg::result_t r;
			v[0] = $signed(it.vec_x);
			v[1] = $signed(it.vec_y);
			v[2] = $signed(it.vec_z);
			a[0] = $signed(it.axis_x);
			a[1] = $signed(it.axis_y);
			a[2] = $signed(it.axis_z);
			c = $signed(it.cos_angle);
			s = $signed(it.sin_angle);
			omc = Q14_ONE - c;
			for (int i = 0; i < 3; i++) begin
				q[i] = (a[i] * s) >>> aavr_pkg::FRAC_W;
				for (int j = i; j < 3; j++) begin
					p = (a[i] * a[j]) >>> aavr_pkg::FRAC_W;
					t = (p * omc) >>> aavr_pkg::FRAC_W;
					m[i][j] = t;
					m[j][i] = t;
				end
			end
			for (int i = 0; i < 3; i++)
				m[i][i] += c;
			// add the cross-product (sine) terms
			m[0][1] -= q[2];
			m[1][0] += q[2];
			m[0][2] += q[1];
			m[2][0] -= q[1];
			m[1][2] -= q[0];
			m[2][1] += q[0];
			// sum each row at full precision, shift once, clamp to 32 bits
			for (int i = 0; i < 3; i++) begin
				acc = (m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2])
					>>> aavr_pkg::FRAC_W;
				if (acc > longint'(VEC_MAX))
					acc = VEC_MAX;
				else if (acc < longint'(VEC_MIN))
					acc = VEC_MIN;
				rot[i] = int'(acc);
			end
			r.rot_x = rot[0];
			r.rot_y = rot[1];
			r.rot_z = rot[2];
			return r;
		endfunction

		function void note_input(aavr_pkg::item_t it);
			expected_rot.push_back(predict_rotation(it));
		endfunction

		function void check_result(aavr_pkg::result_t got);
			aavr_pkg::result_t want;
			if (expected_rot.size() == 0) begin
				$display("%0t: result beat with nothing expected: expected none, actual %h",
					$time, got);
				errors++;
				return;
			end
			want = expected_rot.pop_front();
			if (got.rot_x !== want.rot_x) begin
				$display("%0t: rot_x expected %0d actual %0d", $time, want.rot_x, got.rot_x);
				errors++;
			end
			if (got.rot_y !== want.rot_y) begin
				$display("%0t: rot_y expected %0d actual %0d", $time, want.rot_y, got.rot_y);
				errors++;
			end
			if (got.rot_z !== want.rot_z) begin
				$display("%0t: rot_z expected %0d actual %0d", $time, want.rot_z, got.rot_z);
				errors++;
			end
		endfunction

		function int pending();
			return expected_rot.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	aavr_pkg::item_t   item;
	logic              result_valid;
	logic              result_ready;
	aavr_pkg::result_t result;

	rotation_scoreboard scoreboard = new();
	int                 cycles = 0;
	int                 burst_left = 0;

	axis_angle_vector_rotation dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// 10 ns clock
	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW  clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Check every output beat as it is taken
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			scoreboard.check_result(result);
	end

	function automatic aavr_pkg::item_t make_item(int vx, int vy, int vz, int ax, int ay,
			int az, int c, int s);
		aavr_pkg::item_t it;
		it.vec_x     = vx;
		it.vec_y     = vy;
		it.vec_z     = vz;
		it.axis_x    = 16'(ax);
		it.axis_y    = 16'(ay);
		it.axis_z    = 16'(az);
		it.cos_angle = 16'(c);
		it.sin_angle = 16'(s);
		return it;
	endfunction

	// Mix full-range, modest and extreme vector components
	function automatic int random_component();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
			2: return int'($urandom_range(0, 2 ** 25)) - 2 ** 24;
			default:
				case ($urandom_range(0, 3))
					0: return VEC_MAX;
					1: return VEC_MIN;
					2: return 0;
					default: return -1;
				endcase
		endcase
	endfunction

	// Mostly unit axes with matching cos/sin, some exact multiples of a quarter turn, some raw noise
	function automatic aavr_pkg::item_t random_item();
		aavr_pkg::item_t it;
		int              kind;
		int              comp;
		real             th, ph, ang;
		kind = $urandom_range(0, 99);
		it = make_item(random_component(), random_component(), random_component(),
			0, 0, 0, 0, 0);
		if (kind < 70) begin
			th  = $urandom_range(0, 62831) / 10000.0;
			ph  = $urandom_range(0, 31415) / 10000.0;
			ang = $urandom_range(0, 62831) / 10000.0;
			it.axis_x    = 16'($rtoi(16384.0 * $sin(ph) * $cos(th)));
			it.axis_y    = 16'($rtoi(16384.0 * $sin(ph) * $sin(th)));
			it.axis_z    = 16'($rtoi(16384.0 * $cos(ph)));
			it.cos_angle = 16'($rtoi(16384.0 * $cos(ang)));
			it.sin_angle = 16'($rtoi(16384.0 * $sin(ang)));
		end else if (kind < 85) begin
			comp = $urandom_range(0, 2);
			it.axis_x = (comp == 0) ? 16'(Q14_ONE) : '0;
			it.axis_y = (comp == 1) ? 16'(Q14_ONE) : '0;
			it.axis_z = (comp == 2) ? 16'(Q14_ONE) : '0;
			if ($urandom_range(0, 1) == 1)
				{it.axis_x, it.axis_y, it.axis_z} = {-it.axis_x, -it.axis_y, -it.axis_z};
			case ($urandom_range(0, 3))
				0: {it.cos_angle, it.sin_angle} = {16'(Q14_ONE), 16'(0)};
				1: {it.cos_angle, it.sin_angle} = {16'(0), 16'(Q14_ONE)};
				2: {it.cos_angle, it.sin_angle} = {16'(-Q14_ONE), 16'(0)};
				default: {it.cos_angle, it.sin_angle} = {16'(0), 16'(-Q14_ONE)};
			endcase
		end else begin
			it.vec_x     = $urandom;
			it.vec_y     = $urandom;
			it.vec_z     = $urandom;
			it.axis_x    = 16'($urandom);
			it.axis_y    = 16'($urandom);
			it.axis_z    = 16'($urandom);
			it.cos_angle = 16'($urandom);
			it.sin_angle = 16'($urandom);
		end
		return it;
	endfunction

	// Offer one beat at the falling edge; sometimes insert a gap between bursts
	task automatic offer_item(input aavr_pkg::item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		item       <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		scoreboard.note_input(it);
		@(negedge clk);
	endtask

	// Receiver: stall patterns in segments, with long hold-offs to back up the pipeline
	initial begin
		rx_mode_t mode;
		int       seg_len;
		int       segments;
		int       k;
		result_ready = 1'b0;
		segments = 0;
		@(posedge arst_n);
		forever begin
			segments++;
			if (segments == 4 || $urandom_range(0, 24) == 0) begin
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					result_ready <= 1'b0;
				end
			end else begin
				mode    = rx_mode_t'($urandom_range(0, 3));
				seg_len = $urandom_range(10, 80);
				for (k = 0; k < seg_len; k++) begin
					@(negedge clk);
					case (mode)
						RX_ALWAYS:       result_ready <= 1'b1;
						RX_COIN:         result_ready <= $urandom_range(0, 1);
						RX_ONE_IN_THREE: result_ready <= (k % 3 == 0);
						default:         result_ready <= ($urandom_range(0, 6) != 0);
					endcase
				end
			end
		end
	end

	// Reset, directed beats, random beats, drain, verdict
	initial begin
		item_valid = 1'b0;
		item       = '0;
		arst_n     = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// zero vector, identity with extreme vectors
		offer_item(make_item(0, 0, 0, Q14_ONE, 0, 0, Q14_ONE, 0));
		offer_item(make_item(VEC_MAX, VEC_MIN, 1, Q14_ONE, 0, 0, Q14_ONE, 0));
		// quarter turns about each axis, and a half turn about z
		offer_item(make_item(65536, 0, 0, 0, 0, Q14_ONE, 0, Q14_ONE));
		offer_item(make_item(0, 65536, 0, Q14_ONE, 0, 0, 0, Q14_ONE));
		offer_item(make_item(0, 0, 65536, 0, Q14_ONE, 0, 0, Q14_ONE));
		offer_item(make_item(65536, -65536, 3, 0, 0, Q14_ONE, -Q14_ONE, 0));
		offer_item(make_item(65536, 131072, -7, 0, 0, Q14_ONE, 0, -Q14_ONE));
		offer_item(make_item(-65536, 12345, 99, 0, -Q14_ONE, 0, 0, Q14_ONE));
		// saturation both ways
		offer_item(make_item(VEC_MAX, VEC_MAX, VEC_MAX, Q14_ONE, Q14_ONE, Q14_ONE,
			ANG_MIN, ANG_MAX));
		offer_item(make_item(VEC_MIN, VEC_MIN, VEC_MIN, Q14_ONE, Q14_ONE, Q14_ONE,
			ANG_MIN, ANG_MAX));
		// out-of-range operands at both ends
		offer_item(make_item(VEC_MAX, VEC_MIN, VEC_MAX, ANG_MIN, ANG_MIN, ANG_MIN,
			ANG_MAX, ANG_MIN));
		offer_item(make_item(VEC_MIN, VEC_MAX, VEC_MIN, ANG_MAX, ANG_MAX, ANG_MAX,
			ANG_MIN, ANG_MAX));
		offer_item(make_item(1000, -2000, 3000, ANG_MIN, ANG_MAX, 0, ANG_MIN, ANG_MIN));
		// non-unit axis
		offer_item(make_item(300000, -400000, 500000, 8000, 3000, -100, 11585, 11585));
		offer_item(make_item(65536, 65536, 65536, 1, 1, 1, 0, 0));
		// rounding toward minus infinity on small negatives
		offer_item(make_item(-1, -1, -1, Q14_ONE, 0, 0, 16383, 1));
		offer_item(make_item(-3, 5, -7, 0, Q14_ONE, 0, 16383, -1));
		// all ones, zero matrix, cos and sin both one
		offer_item(make_item(-1, -1, -1, -1, -1, -1, -1, -1));
		offer_item(make_item(VEC_MIN, VEC_MIN, VEC_MIN, 0, 0, 0, 0, 0));
		offer_item(make_item(VEC_MAX, 65536, -65536, 11585, 11585, 0, Q14_ONE, Q14_ONE));
		offer_item(make_item(VEC_MIN, 0, VEC_MAX, -Q14_ONE, -Q14_ONE, -Q14_ONE,
			-Q14_ONE, -Q14_ONE));

		repeat (RANDOM_ITEMS)
			offer_item(random_item());
		item_valid <= 1'b0;

		// wait out the pipeline
		while (scoreboard.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (scoreboard.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
